FILE: sv/rht_pkg.sv
package rht_pkg;

  localparam int KNOB_BITS  = 10;
  localparam int KNOB_FULL  = 1 << KNOB_BITS;
  localparam int TEMP_W     = 14;
  localparam int FRAC_BITS  = 10;
  localparam int RAMP_W     = TEMP_W + FRAC_BITS;
  localparam int ELAPSED_W  = 16;
  localparam int RATE_W     = 16;
  localparam int INCR_W     = ELAPSED_W + RATE_W;
  localparam int HYST_W     = 10;

  // ramp thresholds, quarter degrees with FRAC_BITS fraction bits
  localparam int LOW_JUMP   = 100 << FRAC_BITS;
  localparam int JUMP_TO    = 123290;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_KNOB_MODE   = 3'd0,
    CFG_TARGET_TEMP = 3'd1,
    CFG_ZONE_ENABLE = 3'd2,
    CFG_MIN_TEMP    = 3'd3,
    CFG_MAX_TEMP    = 3'd4,
    CFG_RAMP_STEP   = 3'd5,
    CFG_HYSTERESIS  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                     knob_mode;
    logic signed [TEMP_W-1:0] target_temp;
    logic                     zone_enable;
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic [RATE_W-1:0]        ramp_step;
    logic [HYST_W-1:0]        hysteresis;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target;
    logic                     zone;
  } setpoint_t;

endpackage

FILE: sv/rht_setpoint.sv
module rht_setpoint (
  input  rht_pkg::cfg_t                   cfg,
  input  logic [rht_pkg::KNOB_BITS-1:0]   knob,
  output rht_pkg::setpoint_t              sp
);

  localparam int REST_W = rht_pkg::KNOB_BITS + 1;
  localparam int R20_W  = rht_pkg::KNOB_BITS + 6;
  localparam int DIFF_W = rht_pkg::TEMP_W + 1;
  localparam int PROD_W = DIFF_W + REST_W + 1;

  logic [REST_W-1:0]        rest;
  logic [R20_W-1:0]         rest20;
  logic                     knob_zone;
  logic signed [DIFF_W-1:0] span;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [rht_pkg::TEMP_W-1:0] knob_target;

  // knob reading counts up as the target goes down
  assign rest      = REST_W'(rht_pkg::KNOB_FULL) - {1'b0, knob};
  assign rest20    = R20_W'(rest) * R20_W'(20);
  assign knob_zone = rest20 > R20_W'(rht_pkg::KNOB_FULL);

  assign span    = {cfg.max_temp[rht_pkg::TEMP_W-1], cfg.max_temp}
                 - {cfg.min_temp[rht_pkg::TEMP_W-1], cfg.min_temp};
  assign prod    = {{(PROD_W-DIFF_W){span[DIFF_W-1]}}, span}
                 * $signed({{(PROD_W-REST_W){1'b0}}, rest});
  assign prod_sh = prod >>> rht_pkg::KNOB_BITS;
  // result lies between min and max, so the low bits are exact
  assign knob_target = cfg.min_temp + $signed(prod_sh[rht_pkg::TEMP_W-1:0]);

  always_comb begin
    if (cfg.knob_mode) begin
      sp.target = knob_target;
      sp.zone   = knob_zone;
    end else begin
      sp.target = cfg.target_temp;
      sp.zone   = cfg.zone_enable;
    end
  end

endmodule

FILE: sv/ramped_hysteresis_thermostat.sv
// Pipeline: two register stages, stage 1 and the result register; a result item is registered
// from stage 1 when the result stage advances. Throughput: one item per cycle while results are taken;
// the ramp and heater state update in combinational logic behind stage 1, so items may follow back to back.
// in_tready drops only while both stages hold items and the result is not taken.
// Reset (rst_n low, synchronous): registers return to their defaults, ramp and
// heater state clear, and both pipeline stages empty.
module ramped_hysteresis_thermostat (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rht_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rht_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // elapsed_ms[15:0], knob_reading[25:16], sensor_temp[39:26], sensor_fault[40]
  input  logic [rht_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // heater_drive[0], zone_on[1], target_out[15:2], ramped_target[29:16], fault_out[30]
  output logic [rht_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int TW    = rht_pkg::TEMP_W;
  localparam int RW    = rht_pkg::RAMP_W;
  localparam int IW    = rht_pkg::INCR_W;
  localparam int SUM_W = IW + 2;
  localparam int HC_W  = RW + 2;

  localparam logic signed [RW-1:0]    LOW_JUMP_C = RW'(rht_pkg::LOW_JUMP);
  localparam logic signed [RW-1:0]    JUMP_TO_C  = RW'(rht_pkg::JUMP_TO);
  localparam logic signed [RW-1:0]    RAMP_MAX_C = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] RAMP_MAX_S = {{(SUM_W-RW+1){1'b0}}, {(RW-1){1'b1}}};

  // configuration registers
  rht_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.knob_mode   <= 1'b0;
      cfg_r.target_temp <= '0;
      cfg_r.zone_enable <= 1'b0;
      cfg_r.min_temp    <= '0;
      cfg_r.max_temp    <= TW'(1200);
      cfg_r.ramp_step   <= rht_pkg::RATE_W'(4);
      cfg_r.hysteresis  <= rht_pkg::HYST_W'(8);
    end else if (cfg_we) begin
      case (rht_pkg::cfg_idx_t'(cfg_addr))
        rht_pkg::CFG_KNOB_MODE:   cfg_r.knob_mode   <= cfg_wdata[0];
        rht_pkg::CFG_TARGET_TEMP: cfg_r.target_temp <= cfg_wdata[TW-1:0];
        rht_pkg::CFG_ZONE_ENABLE: cfg_r.zone_enable <= cfg_wdata[0];
        rht_pkg::CFG_MIN_TEMP:    cfg_r.min_temp    <= cfg_wdata[TW-1:0];
        rht_pkg::CFG_MAX_TEMP:    cfg_r.max_temp    <= cfg_wdata[TW-1:0];
        rht_pkg::CFG_RAMP_STEP:   cfg_r.ramp_step   <= cfg_wdata[rht_pkg::RATE_W-1:0];
        rht_pkg::CFG_HYSTERESIS:  cfg_r.hysteresis  <= cfg_wdata[rht_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // input field unpack
  logic [rht_pkg::ELAPSED_W-1:0] in_elapsed;
  logic [rht_pkg::KNOB_BITS-1:0] in_knob;
  logic signed [TW-1:0]          in_sensor;
  logic                          in_fault;

  assign in_elapsed = in_tdata[15:0];
  assign in_knob    = in_tdata[25:16];
  assign in_sensor  = in_tdata[39:26];
  assign in_fault   = in_tdata[40];

  rht_pkg::setpoint_t sp;

  rht_setpoint u_setpoint (
    .cfg  (cfg_r),
    .knob (in_knob),
    .sp   (sp)
  );

  // handshake: the result stage advances when empty or taken
  logic adv;
  logic s1_v_r;
  logic out_v_r;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv || !s1_v_r;

  // stage 1: setpoint and ramp increment
  rht_pkg::setpoint_t   s1_sp_r;
  logic [IW-1:0]        s1_incr_r;
  logic signed [TW-1:0] s1_sensor_r;
  logic                 s1_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sp_r     <= sp;
      s1_incr_r   <= IW'(in_elapsed) * IW'(cfg_r.ramp_step);
      s1_sensor_r <= in_sensor;
      s1_fault_r  <= in_fault;
    end
  end

  // stage 2: ramp and hysteresis against the live state
  logic signed [RW-1:0]    ramp_r, ramp_nxt;
  logic                    drive_r, drive_nxt;
  logic signed [RW-1:0]    tscaled;
  logic signed [RW-1:0]    base;
  logic signed [SUM_W-1:0] sum;
  logic signed [RW-1:0]    sat;
  logic signed [RW-1:0]    up;
  logic signed [RW-1:0]    clamped;
  logic signed [HC_W-1:0]  err;
  logic signed [HC_W-1:0]  half;
  logic                    over, under;
  logic                    step;

  assign step    = s1_v_r && adv;
  assign tscaled = {s1_sp_r.target, {rht_pkg::FRAC_BITS{1'b0}}};
  // a ramp still below room level starts from just above it
  assign base    = (ramp_r < LOW_JUMP_C) ? JUMP_TO_C : ramp_r;
  assign sum     = $signed({{(SUM_W-RW){base[RW-1]}}, base})
                 + $signed({{(SUM_W-IW){1'b0}}, s1_incr_r});
  assign sat     = (sum > RAMP_MAX_S) ? RAMP_MAX_C : sum[RW-1:0];
  assign up      = (ramp_r < tscaled) ? sat : ramp_r;
  assign clamped = (up > tscaled) ? tscaled : up;
  assign ramp_nxt = s1_sp_r.zone ? clamped : '0;

  assign err   = $signed({{2{s1_sensor_r[TW-1]}}, s1_sensor_r, {rht_pkg::FRAC_BITS{1'b0}}})
               - $signed({{(HC_W-RW){ramp_nxt[RW-1]}}, ramp_nxt});
  assign half  = $signed({{(HC_W-rht_pkg::HYST_W-rht_pkg::FRAC_BITS+1){1'b0}},
                          cfg_r.hysteresis, {(rht_pkg::FRAC_BITS-1){1'b0}}});
  assign over  = err > half;
  assign under = err < -half;

  always_comb begin
    if (s1_sp_r.zone && !s1_fault_r) begin
      drive_nxt = drive_r ? !over : under;
    end else begin
      drive_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r  <= '0;
      drive_r <= 1'b0;
    end else if (step) begin
      ramp_r  <= ramp_nxt;
      drive_r <= drive_nxt;
    end
  end

  // result register
  logic                 out_heater_r;
  logic                 out_zone_r;
  logic signed [TW-1:0] out_target_r;
  logic signed [TW-1:0] out_ramped_r;
  logic                 out_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_heater_r <= drive_nxt;
      out_zone_r   <= s1_sp_r.zone;
      out_target_r <= s1_sp_r.target;
      out_ramped_r <= ramp_nxt[RW-1:rht_pkg::FRAC_BITS];
      out_fault_r  <= s1_fault_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_fault_r, out_ramped_r, out_target_r,
                       out_zone_r, out_heater_r};

  // a stage 1 item that cannot move must block the input
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input accepted while stage 1 is blocked");

  // a zone that is off leaves a zero ramp and no heat
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && !s1_sp_r.zone) |=> (ramp_r == '0 && !drive_r))
    else $error("ramp or drive kept with zone off");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_fault_r || !out_zone_r)) |-> !out_heater_r)
    else $error("heater driven on fault or with zone off");

  // the ramp never passes the target it follows
  assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (ramp_r <= {$past(s1_sp_r.target), {rht_pkg::FRAC_BITS{1'b0}}}
              || ramp_r == '0))
    else $error("ramp above target");

endmodule
